### rtl/multi_pattern_byte_patcher_macros.svh
// Assertion helpers for the byte patcher.
`ifndef MULTI_PATTERN_BYTE_PATCHER_MACROS_SVH
`define MULTI_PATTERN_BYTE_PATCHER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MPBP_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define MPBP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/mpbp_pkg.sv
`default_nettype none
package mpbp_pkg;
   localparam int MAX_PATTERNS    = 8;
   localparam int MAX_PATTERN_LEN = 16;
   localparam int OFFSET_BITS     = 24;
   localparam int ENT_W   = $clog2(MAX_PATTERNS);
   localparam int BYTE_W  = $clog2(MAX_PATTERN_LEN);
   localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
   localparam int TBL_DEPTH = MAX_PATTERNS * MAX_PATTERN_LEN;
   localparam int TBL_AW  = $clog2(TBL_DEPTH);
   localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

   // input actions
   localparam logic [1:0] ACT_IMAGE = 2'd0;
   localparam logic [1:0] ACT_LOAD_BYTE = 2'd1;
   localparam logic [1:0] ACT_LOAD_LEN = 2'd2;

   // output kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;
endpackage
`default_nettype wire

### rtl/mpbp_ram.sv
`default_nettype none
module mpbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/multi_pattern_byte_patcher.sv
// A word that fills the window, or a last word, tries each active pattern at the head
// in turn: one longer than the held bytes is skipped, length 0 is a match, a compare
// stops at the first mismatching byte, and a match copies its replacement bytes in;
// then the head byte is output. New words stall while this runs. A last word drains
// each held byte so, then one summary per cycle while the output is not stalled.
// Reset (synchronous, active high) clears window, counts, offsets, lengths, register.
`default_nettype none
`include "multi_pattern_byte_patcher_macros.svh"
module multi_pattern_byte_patcher
   import mpbp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   input  wire logic [2:0]  req_entry_index,
   input  wire logic [3:0]  req_byte_index,
   input  wire logic [7:0]  req_pattern_byte,
   input  wire logic [7:0]  req_replace_byte,
   input  wire logic [4:0]  req_pattern_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [2:0]       rsp_summary_index,
   output logic [23:0]      rsp_match_count,
   output logic [23:0]      rsp_last_offset,
   output logic             rsp_run_end
);
   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PAT   = 4'd1;  // pick next pattern
   localparam logic [3:0] S_CMPRD = 4'd2;  // table read issued
   localparam logic [3:0] S_CMP   = 4'd3;  // compare one byte
   localparam logic [3:0] S_CPY   = 4'd4;  // copy one byte
   localparam logic [3:0] S_EMIT  = 4'd5;  // output head byte
   localparam logic [3:0] S_SUM   = 4'd6;  // output summaries
   localparam logic [3:0] S_WAIT  = 4'd7;  // end of stream: clear run state

   logic [3:0]        state_ff, state_in, ret_ff, ret_in;
   logic [3:0]        pcount_ff;
   logic [7:0]        window_ff [MAX_PATTERN_LEN];
   logic [7:0]        window_in [MAX_PATTERN_LEN];
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff [MAX_PATTERNS];
   logic [23:0]       cnt_ff [MAX_PATTERNS];
   logic [23:0]       off_ff [MAX_PATTERNS];
   logic [ENT_W:0]    pat_ff, pat_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic              flush_ff, flush_in;
   logic              hit_ff, hit_in;
   logic [ENT_W-1:0]  pidx;
   logic [ENT_W:0]    act;

   // output register
   logic        ov_ff, ov_in, okind_ff, okind_in, oend_ff, oend_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [23:0] ocnt_ff, ocnt_in, ooff_ff, ooff_in;

   // pattern/replace table: one RAM, 16-bit words
   logic              tw_en;
   logic [TBL_AW-1:0] tw_addr, tr_addr;
   logic [15:0]       tr_data;
   logic [BYTE_W-1:0] kb;

   assign kb = k_ff[BYTE_W-1:0];
   assign pidx = pat_ff[ENT_W-1:0];
   assign act = (pcount_ff > 4'(MAX_PATTERNS)) ? (ENT_W+1)'(MAX_PATTERNS)
                                                : (ENT_W+1)'(pcount_ff);
   assign tw_en = (state_ff == S_IDLE) && req_valid && (req_action == ACT_LOAD_BYTE)
                  && (fill_ff == '0);
   assign tw_addr = {req_entry_index[ENT_W-1:0], req_byte_index[BYTE_W-1:0]};
   assign tr_addr = {pidx, kb};

   mpbp_ram #(.WIDTH(16), .DEPTH(TBL_DEPTH)) u_tbl (
      .clock(clock), .wr_en(tw_en), .wr_addr(tw_addr),
      .wr_data({req_pattern_byte, req_replace_byte}),
      .rd_addr(tr_addr), .rd_data(tr_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_kind = okind_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_summary_index = oidx_ff;
   assign rsp_match_count = ocnt_ff;
   assign rsp_last_offset = ooff_ff;
   assign rsp_run_end = oend_ff;

   logic out_free;
   assign out_free = !ov_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      window_in = window_ff; fill_in = fill_ff; pos_in = pos_ff;
      pat_in = pat_ff; k_in = k_ff; flush_in = flush_ff; hit_in = hit_ff;
      ov_in = ov_ff && rsp_stall;
      okind_in = okind_ff; obyte_in = obyte_ff; oidx_in = oidx_ff;
      ocnt_in = ocnt_ff; ooff_in = ooff_ff; oend_in = oend_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_action == ACT_IMAGE) begin
               if (fill_ff < LEN_W'(MAX_PATTERN_LEN)) begin
                  window_in[fill_ff[BYTE_W-1:0]] = req_data_byte;
                  fill_in = fill_ff + 1'b1;
               end
               flush_in = req_last;
               pat_in = '0;
               if (req_last || fill_in >= LEN_W'(MAX_PATTERN_LEN)) begin
                  state_in = S_PAT;
               end
            end
         end
         S_PAT: begin
            k_in = '0;
            if (fill_ff == '0) begin
               pat_in = '0;
               state_in = (act == '0) ? S_WAIT : S_SUM;
               ret_in = S_IDLE;
            end else if (pat_ff >= act) begin
               state_in = S_EMIT;
            end else if (len_ff[pidx] > fill_ff) begin
               pat_in = pat_ff + 1'b1;
            end else begin
               hit_in = 1'b1;
               state_in = S_CMPRD;
            end
         end
         S_CMPRD: begin
            if (k_ff == len_ff[pidx]) begin
               // zero length: a match with nothing to copy
               pat_in = pat_ff + 1'b1;
               state_in = S_PAT;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (window_ff[kb] != tr_data[15:8]) begin
               hit_in = 1'b0;
               k_in = len_ff[pidx];
            end else begin
               k_in = k_ff + 1'b1;
            end
            state_in = S_CMPRD;
            if (hit_in && k_in == len_ff[pidx]) k_in = '0;
            if (hit_in && k_ff + 1'b1 == len_ff[pidx]) state_in = S_CPY;
            if (!hit_in) begin
               pat_in = pat_ff + 1'b1;
               state_in = S_PAT;
            end
         end
         S_CPY: begin
            // read data for index k lands in the cycle after its address; use
            // CPY as a two-phase step keyed on hit_ff
            if (hit_ff) begin
               hit_in = 1'b0;  // address settles this cycle
            end else begin
               window_in[kb] = tr_data[7:0];
               if (k_ff + 1'b1 == len_ff[pidx]) begin
                  pat_in = pat_ff + 1'b1;
                  state_in = S_PAT;
               end else begin
                  k_in = k_ff + 1'b1;
                  hit_in = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = KIND_BYTE; obyte_in = window_ff[0];
               oidx_in = '0; ocnt_in = '0; ooff_in = '0;
               oend_in = !flush_ff || (fill_ff == LEN_W'(1) && act == '0);
               for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[MAX_PATTERN_LEN-1] = '0;
               fill_in = fill_ff - 1'b1;
               pos_in = pos_ff + 1'b1;
               pat_in = '0;
               state_in = flush_ff ? S_PAT : S_IDLE;
               if (flush_ff && fill_in == '0 && act == '0) begin
                  state_in = S_WAIT; ret_in = S_IDLE;
               end
            end
         end
         S_SUM: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = KIND_SUMMARY; obyte_in = '0;
               oidx_in = 3'(pidx); ocnt_in = cnt_ff[pidx]; ooff_in = off_ff[pidx];
               oend_in = (pat_ff + 1'b1 == act);
               pat_in = pat_ff + 1'b1;
               if (oend_in) begin
                  state_in = S_WAIT; ret_in = S_IDLE;
               end
            end
         end
         S_WAIT: begin
            // end of stream: clear run state
            for (int i = 0; i < MAX_PATTERN_LEN; i++) window_in[i] = '0;
            fill_in = '0; pos_in = '0; flush_in = 1'b0;
            state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // per-pattern counts, offsets, lengths
   logic match_done;
   assign match_done = (state_ff == S_CPY) && !hit_ff && (k_ff + 1'b1 == len_ff[pidx]);
   logic zero_hit;
   assign zero_hit = (state_ff == S_CMPRD) && hit_ff && (len_ff[pidx] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= S_IDLE; pcount_ff <= '0; fill_ff <= '0;
         pos_ff <= '0; pat_ff <= '0; k_ff <= '0; flush_ff <= 1'b0; hit_ff <= 1'b0;
         ov_ff <= 1'b0;
         for (int i = 0; i < MAX_PATTERN_LEN; i++) window_ff[i] <= '0;
         for (int i = 0; i < MAX_PATTERNS; i++) begin
            len_ff[i] <= '0; cnt_ff[i] <= '0; off_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; fill_ff <= fill_in; pos_ff <= pos_in;
         pat_ff <= pat_in; k_ff <= k_in; flush_ff <= flush_in; hit_ff <= hit_in;
         window_ff <= window_in; ov_ff <= ov_in;
         if (csr_wr_en) pcount_ff <= csr_wr_data;
         if (state_ff == S_IDLE && req_valid && req_action == ACT_LOAD_LEN
             && fill_ff == '0) begin
            len_ff[req_entry_index[ENT_W-1:0]] <=
               (req_pattern_length > 5'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN)
                                                          : LEN_W'(req_pattern_length);
         end
         if (match_done || zero_hit) begin
            if (cnt_ff[pidx] != COUNT_MAX) cnt_ff[pidx] <= cnt_ff[pidx] + 1'b1;
            off_ff[pidx] <= 24'(pos_ff);
         end
         if (state_ff == S_WAIT) begin
            for (int i = 0; i < MAX_PATTERNS; i++) begin
               cnt_ff[i] <= '0; off_ff[i] <= '0;
            end
         end
      end
      okind_ff <= okind_in; obyte_ff <= obyte_in; oidx_ff <= oidx_in;
      ocnt_ff <= ocnt_in; ooff_ff <= ooff_in; oend_ff <= oend_in;
   end

   `MPBP_ASSERT_IMPL(a_fill_range, clock, reset, 1'b1, fill_ff <= LEN_W'(MAX_PATTERN_LEN), "window overfilled")
   `MPBP_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte), "stalled word changed")
   `MPBP_ASSERT_IMPL(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall, "busy without stall")
endmodule
`default_nettype wire

### bench/multi_pattern_byte_patcher_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module multi_pattern_byte_patcher_tb
   import mpbp_pkg::*;
();

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int DRAIN_WAIT  = 500;

   typedef struct {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       last;
      logic [2:0] entry_index;
      logic [3:0] byte_index;
      logic [7:0] pattern_byte;
      logic [7:0] replace_byte;
      logic [4:0] pattern_length;
   } req_word_type;

   typedef struct {
      logic        kind;
      logic [7:0]  out_byte;
      logic [2:0]  summary_index;
      logic [23:0] match_count;
      logic [23:0] last_offset;
      logic        run_end;
   } rsp_word_type;

   // Patch predictor plus queue of expected output words
   class patch_scoreboard_type;
      logic [7:0]  win[MAX_PATTERN_LEN];
      int          fill;
      logic [23:0] pos;
      logic [7:0]  pat[MAX_PATTERNS][MAX_PATTERN_LEN];
      logic [7:0]  rep[MAX_PATTERNS][MAX_PATTERN_LEN];
      int          lens[MAX_PATTERNS];
      logic [23:0] hits[MAX_PATTERNS];
      logic [23:0] offs[MAX_PATTERNS];
      logic [3:0]  pattern_count;
      rsp_word_type patched_q[$];
      int          errors;

      function new();
         for (int i = 0; i < MAX_PATTERN_LEN; i++) win[i] = 0;
         for (int p = 0; p < MAX_PATTERNS; p++) begin
            lens[p] = 0;
            hits[p] = 0;
            offs[p] = 0;
         end
         fill = 0;
         pos = 0;
         pattern_count = 0;
         errors = 0;
      endfunction

      function int active();
         return (pattern_count > MAX_PATTERNS) ? MAX_PATTERNS : int'(pattern_count);
      endfunction

      // try every active pattern at the head, then release the head byte
      function void release_head();
         rsp_word_type w;
         bit hit;
         for (int p = 0; p < active(); p++) begin
            if (lens[p] > fill) continue;
            hit = 1;
            for (int k = 0; k < lens[p]; k++)
               if (win[k] != pat[p][k]) hit = 0;
            if (!hit) continue;
            for (int k = 0; k < lens[p]; k++) win[k] = rep[p][k];
            if (hits[p] != COUNT_MAX) hits[p]++;
            offs[p] = pos;
         end
         w = '{KIND_BYTE, win[0], 3'd0, 24'd0, 24'd0, 1'b0};
         patched_q = {patched_q, w};
         for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) win[i] = win[i + 1];
         win[MAX_PATTERN_LEN - 1] = 0;
         fill--;
         pos++;
      endfunction

      function void note_input(req_word_type r);
         int start;
         rsp_word_type w;
         start = patched_q.size();
         case (r.action)
            ACT_LOAD_BYTE: begin
               if (fill == 0) begin
                  pat[r.entry_index][r.byte_index] = r.pattern_byte;
                  rep[r.entry_index][r.byte_index] = r.replace_byte;
               end
            end
            ACT_LOAD_LEN: begin
               if (fill == 0)
                  lens[r.entry_index] = (r.pattern_length > MAX_PATTERN_LEN) ?
                                        MAX_PATTERN_LEN : int'(r.pattern_length);
            end
            ACT_IMAGE: begin
               if (fill < MAX_PATTERN_LEN) begin
                  win[fill] = r.data_byte;
                  fill++;
               end
               if (!r.last) begin
                  if (fill >= MAX_PATTERN_LEN) release_head();
               end else begin
                  while (fill > 0) release_head();
                  for (int p = 0; p < active(); p++) begin
                     w = '{KIND_SUMMARY, 8'd0, 3'(p), hits[p], offs[p], 1'b0};
                     patched_q = {patched_q, w};
                  end
                  for (int p = 0; p < MAX_PATTERNS; p++) begin
                     hits[p] = 0;
                     offs[p] = 0;
                  end
                  pos = 0;
               end
               if (patched_q.size() > start) patched_q[$].run_end = 1;
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (patched_q.size() == 0) begin
            $error("unexpected output word: kind %0d byte %0h", got.kind, got.out_byte);
            errors++;
            return;
         end
         want = patched_q.pop_front();
         if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.out_byte != want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.summary_index != want.summary_index) begin
            $error("summary_index: expected %0d, got %0d",
                   want.summary_index, got.summary_index);
            errors++;
         end
         if (got.match_count != want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
            errors++;
         end
         if (got.last_offset != want.last_offset) begin
            $error("last_offset: expected %0d, got %0d", want.last_offset, got.last_offset);
            errors++;
         end
         if (got.run_end != want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [3:0]  csr_wr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_action = 0;
   logic [7:0]  req_data_byte = 0;
   logic        req_last = 0;
   logic [2:0]  req_entry_index = 0;
   logic [3:0]  req_byte_index = 0;
   logic [7:0]  req_pattern_byte = 0;
   logic [7:0]  req_replace_byte = 0;
   logic [4:0]  req_pattern_length = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_summary_index;
   logic [23:0] rsp_match_count;
   logic [23:0] rsp_last_offset;
   logic        rsp_run_end;

   patch_scoreboard_type sb = new();
   bit  idle_en = 1;
   int  cycles = 0;

   multi_pattern_byte_patcher u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_data_byte(req_data_byte), .req_last(req_last),
      .req_entry_index(req_entry_index), .req_byte_index(req_byte_index),
      .req_pattern_byte(req_pattern_byte), .req_replace_byte(req_replace_byte),
      .req_pattern_length(req_pattern_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind), .rsp_out_byte(rsp_out_byte),
      .rsp_summary_index(rsp_summary_index), .rsp_match_count(rsp_match_count),
      .rsp_last_offset(rsp_last_offset), .rsp_run_end(rsp_run_end)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // output monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_kind, rsp_out_byte, rsp_summary_index,
                           rsp_match_count, rsp_last_offset, rsp_run_end});
   end

   // receiver stall bursts
   initial begin
      forever begin
         @(negedge clock);
         if (idle_en && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_stall = 0;
         end
      end
   end

   task automatic send(req_word_type w);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat ($urandom_range(1, 13) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_action = w.action;
      req_data_byte = w.data_byte;
      req_last = w.last;
      req_entry_index = w.entry_index;
      req_byte_index = w.byte_index;
      req_pattern_byte = w.pattern_byte;
      req_replace_byte = w.replace_byte;
      req_pattern_length = w.pattern_length;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note_input(w);
   endtask

   function automatic req_word_type image(logic [7:0] b, logic lst);
      return '{ACT_IMAGE, b, lst, 3'($urandom), 4'($urandom), 8'($urandom),
               8'($urandom), 5'($urandom)};
   endfunction

   function automatic req_word_type load_byte(int e, int b, logic [7:0] pb, logic [7:0] rb);
      return '{ACT_LOAD_BYTE, 8'($urandom), 1'($urandom), 3'(e), 4'(b), pb, rb,
               5'($urandom)};
   endfunction

   function automatic req_word_type load_len(int e, logic [4:0] l);
      return '{ACT_LOAD_LEN, 8'($urandom), 1'($urandom), 3'(e), 4'($urandom),
               8'($urandom), 8'($urandom), l};
   endfunction

   // small alphabet so that matches are common
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 4))
         0: return 8'($urandom);
         1, 2: return 8'h3C;
         default: return 8'hC3;
      endcase
   endfunction

   function automatic logic [4:0] pick_len();
      case ($urandom_range(0, 15))
         0: return 5'd0;
         1: return 5'd16;
         2: return 5'($urandom_range(17, 31));
         default: return 5'($urandom_range(1, 3));
      endcase
   endfunction

   // idle wait before touching the register
   task automatic settle();
      @(negedge clock);
      req_valid = 0;
      while (sb.patched_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_pattern_count(logic [3:0] v);
      @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      sb.pattern_count = v;
   endtask

   // only bytes below the length are ever compared or copied
   task automatic reload_entry_len(int e, logic [4:0] l);
      int n;
      n = (l > 5'(MAX_PATTERN_LEN)) ? MAX_PATTERN_LEN : int'(l);
      for (int b = 0; b < n; b++)
         send(load_byte(e, b, pick_byte(), pick_byte()));
      send(load_len(e, l));
   endtask

   task automatic reload_entry(int e);
      reload_entry_len(e, pick_len());
   endtask

   // one image stream; noise mixed in while the window is busy
   task automatic stream(int n);
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
               0: send(load_byte($urandom_range(0, 7), $urandom_range(0, 15),
                                 8'($urandom), 8'($urandom)));
               1: send(load_len($urandom_range(0, 7), 5'($urandom)));
               default: send('{2'd3, 8'($urandom), 1'($urandom), 3'($urandom),
                               4'($urandom), 8'($urandom), 8'($urandom), 5'($urandom)});
            endcase
         end
         send(image(pick_byte(), i == n - 1));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // lengths start at zero, so an entry needs bytes only below its length
      write_pattern_count(4'd0);
      send(load_byte(7, 15, 8'hFF, 8'h00));
      send(load_byte(0, 0, 8'h3C, 8'hC3));
      send(load_len(0, 5'd1));
      send(load_len(1, 5'd0));
      reload_entry_len(2, 5'd31);

      // directed: no patterns active, single byte, short stream, odd actions
      send(image(8'h00, 1'b1));
      send(image(8'hFF, 1'b0));
      send('{2'd3, 8'h55, 1'b1, 3'd7, 4'd15, 8'hFF, 8'hFF, 5'd31});
      send(image(8'h3C, 1'b1));
      settle();
      write_pattern_count(4'd8);
      send(image(8'h3C, 1'b0));
      send(load_len(0, 5'd2));
      send(load_byte(0, 0, 8'h00, 8'h00));
      for (int i = 0; i < 17; i++) send(image(i[0] ? 8'hC3 : 8'h3C, 1'b0));
      send(image(8'hFF, 1'b1));
      settle();
      write_pattern_count(4'd15);
      send(image(8'h3C, 1'b1));

      // random phases with register changes between them
      for (int ph = 0; ph < 5; ph++) begin
         settle();
         idle_en = (ph < 3) ? ($urandom_range(0, 3) != 0) : 0;
         write_pattern_count(ph == 0 ? 4'd1 : 4'($urandom_range(0, 15)));
         repeat ($urandom_range(1, 2)) reload_entry($urandom_range(0, 7));
         stream($urandom_range(2, 10));
      end

      settle();
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
